// ----- src/avs_pkg.sv -----
`timescale 1ns / 1ps

package avs_pkg;

    // Default sizing
    localparam int NUM_HARMONICS_DEF = 8;
    localparam int SINE_DEPTH_DEF    = 1024;

    // Field and datapath widths
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W   = 24;
    localparam int LEN_W     = 24;
    localparam int STEP_W    = 23;
    localparam int LEVEL_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int TBL_W     = 16;
    localparam int FACTOR_W  = 32;
    localparam int ACC_W     = 37;
    localparam int ENV_W     = 17;
    localparam int NUMER_W   = 40;
    localparam int QUOT_W    = 16;
    localparam int HIDX_W    = 3;

    // Command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOTAL_LENGTH,
        REG_ATTACK_LENGTH,
        REG_DECAY_LENGTH,
        REG_RELEASE_LENGTH,
        REG_SUSTAIN_LEVEL,
        REG_FUNDAMENTAL_STEP,
        REG_VIBRATO_STEP,
        REG_VIBRATO_DEPTH
    } cfg_reg_t;

    // Odd sine polynomial in Q30, lowest order first
    localparam logic [31:0] POLY_COEF [7] = '{
        32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995,
        32'd172272, 32'd3864, 32'd61
    };

    // Voice sequencer states
    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_VIB,
        ST_H_RD,
        ST_H_TAB,
        ST_H_ACC,
        ST_ENV_WAIT,
        ST_SCALE,
        ST_SAT,
        ST_EMIT
    } voice_state_t;

    // Table builder states
    typedef enum logic [3:0] {
        TI_SQ,
        TI_U,
        TI_MUL,
        TI_SUB,
        TI_TP,
        TI_TPS,
        TI_SC,
        TI_WR,
        TI_DONE
    } tinit_state_t;

    // Envelope segment in force
    typedef enum logic [1:0] {
        ENV_ATTACK,
        ENV_DECAY,
        ENV_RELEASE,
        ENV_SUSTAIN
    } env_sel_t;

    // Divider request and status
    typedef struct packed {
        logic               start;
        logic [NUMER_W-1:0] numer;
        logic [LEN_W-1:0]   denom;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

// ----- src/additive_voice_synth.sv -----
`timescale 1ns / 1ps

// Additive synthesizer voice: harmonic sine bank with vibrato and an ADSR envelope.
// Input channel (in_valid/in_ready): one beat is a tick (cmd = CMD_TICK), which
// makes the next sample, or a load (cmd = CMD_LOAD), which writes the gain of one
// harmonic. Every input beat yields exactly one output beat (out_valid/out_ready)
// carrying sample_value and finished.
// Configuration: cfg_write with cfg_index/cfg_data; the user must write only while
// the block is idle, as the block itself does not enforce it.
// Sequence: a load or a tick past the end of the voice goes from idle straight to the
// emit state; a sample tick first walks the harmonics through the phase, gain and
// sine memories (read, table and accumulate states for each), then waits for the
// envelope divider while it is running, then scales and saturates the sum.
// One item is worked at a time; the next one is taken as soon as the sequencer is
// back at idle, even while the last output beat still waits in the output register.
// Reset: the quarter-sine table is built into its memory first, during which
// in_ready stays low.
// Receiver stall: a finished beat holds in the output register; a further result
// waits in the sequencer until that register frees up.
module additive_voice_synth #(
    parameter int NUM_HARMONICS    = avs_pkg::NUM_HARMONICS_DEF,
    parameter int SINE_TABLE_DEPTH = avs_pkg::SINE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [avs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [avs_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [avs_pkg::HIDX_W-1:0]          harmonic_index,
    input  logic signed [avs_pkg::GAIN_W-1:0]   gain_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [avs_pkg::SAMPLE_W-1:0] sample_value,
    output logic                                finished
);

    import avs_pkg::*;

    localparam int KW   = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1;
    localparam int AW   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int FK_W = STEP_W + $clog2(NUM_HARMONICS + 1);
    localparam int SC_W = ACC_W + ENV_W + 1;

    // Configuration registers
    logic [LEN_W-1:0]   total_reg, attack_reg, decay_reg, release_reg;
    logic [LEVEL_W-1:0] sustain_reg, vdepth_reg;
    logic [STEP_W-1:0]  fstep_reg, vstep_reg;

    // Sequencer and state
    voice_state_t state_reg, state_next;
    logic [KW-1:0]            k_reg;
    logic [PHASE_W-1:0]       vib_phase_reg;
    logic [LEN_W-1:0]         count_reg;
    logic [NUM_HARMONICS-1:0] gain_vld_reg;
    logic [NUM_HARMONICS-1:0] phase_vld_reg;
    logic                     out_valid_reg;

    // Datapath registers
    logic [FACTOR_W-1:0]        factor_reg;
    logic [FK_W-1:0]            fk_reg;
    logic [PHASE_W-1:0]         phase_cur_reg;
    logic                       neg_reg;
    logic [PHASE_W-1:0]         step_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    env_sel_t                   env_sel_reg;
    logic [ENV_W-1:0]           env_reg;
    logic signed [SC_W-1:0]     scale_reg;
    logic signed [SAMPLE_W-1:0] res_sample_reg, sample_reg;
    logic                       res_fin_reg, fin_reg;

    // Control
    logic in_fire, emit_load, gain_we, phase_we, gain_hit, done_now, tbl_done;
    logic [5:0] idx_ext;

    // Memory ports
    logic [PHASE_W-1:0] phase_rd, phase_cur, phase_wr;
    logic [GAIN_W-1:0]  gain_rd;
    logic signed [GAIN_W-1:0] gain_cur;
    logic [AW-1:0]      tbl_rd_addr, tbl_wr_addr;
    logic [TBL_W-1:0]   tbl_rd, tbl_wr_data;
    logic               tbl_we;
    logic [KW-1:0]      gain_wr_addr;

    // Arithmetic
    logic signed [SAMPLE_W-1:0]   sin_val;
    logic signed [32:0]           vib_prod;
    logic signed [33:0]           factor_sum;
    logic [FK_W+FACTOR_W-1:0]     step_prod;
    logic signed [31:0]           hprod;
    logic [LEVEL_W-1:0]           s_sat;
    logic [LEN_W-1:0]             since_a;
    logic [LEN_W:0]               n_plus_r;
    env_sel_t                     env_sel;
    div_req_t                     div_req;
    div_rsp_t                     div_rsp;
    logic signed [SC_W-ACC_W-1:0] env_s;
    logic signed [SC_W-31:0]      y_full;

    function automatic logic [AW-1:0] tbl_addr(input logic [PHASE_W-1:0] ph);
        logic [22+AW-1:0] prod;
        logic [AW-1:0]    idx;
        prod = (22+AW)'(ph[21:0]) * (22+AW)'(SINE_TABLE_DEPTH);
        idx  = prod[22+AW-1:22];
        return ph[22] ? (AW'(SINE_TABLE_DEPTH) - idx) : idx;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            attack_reg  <= '0;
            decay_reg   <= '0;
            release_reg <= '0;
            sustain_reg <= '0;
            fstep_reg   <= '0;
            vstep_reg   <= '0;
            vdepth_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TOTAL_LENGTH:     total_reg   <= cfg_data;
                REG_ATTACK_LENGTH:    attack_reg  <= cfg_data;
                REG_DECAY_LENGTH:     decay_reg   <= cfg_data;
                REG_RELEASE_LENGTH:   release_reg <= cfg_data;
                REG_SUSTAIN_LEVEL:    sustain_reg <= cfg_data[LEVEL_W-1:0];
                REG_FUNDAMENTAL_STEP: fstep_reg   <= cfg_data[STEP_W-1:0];
                REG_VIBRATO_STEP:     vstep_reg   <= cfg_data[STEP_W-1:0];
                REG_VIBRATO_DEPTH:    vdepth_reg  <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Memories and helpers
    avs_tbl_init #(.DEPTH(SINE_TABLE_DEPTH)) u_tbl_init (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_we),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .done    (tbl_done)
    );

    avs_ram #(.WIDTH(TBL_W), .DEPTH(SINE_TABLE_DEPTH + 1)) u_tbl_ram (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd)
    );

    avs_ram #(.WIDTH(PHASE_W), .DEPTH(NUM_HARMONICS)) u_phase_ram (
        .clk     (clk),
        .wr_en   (phase_we),
        .wr_addr (k_reg),
        .wr_data (phase_wr),
        .rd_addr (k_reg),
        .rd_data (phase_rd)
    );

    avs_ram #(.WIDTH(GAIN_W), .DEPTH(NUM_HARMONICS)) u_gain_ram (
        .clk     (clk),
        .wr_en   (gain_we),
        .wr_addr (gain_wr_addr),
        .wr_data (gain_value),
        .rd_addr (k_reg),
        .rd_data (gain_rd)
    );

    avs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Entries never written read as zero
    assign phase_cur    = phase_vld_reg[k_reg] ? phase_rd : '0;
    assign gain_cur     = gain_vld_reg[k_reg] ? $signed(gain_rd) : '0;
    assign phase_wr     = phase_cur_reg + step_reg;
    assign idx_ext      = 6'(harmonic_index);
    assign gain_hit     = (idx_ext < 6'(NUM_HARMONICS));
    assign gain_wr_addr = idx_ext[KW-1:0];
    assign done_now     = (count_reg >= total_reg);
    assign in_fire      = in_valid && in_ready;

    // Sine and vibrato arithmetic
    assign tbl_rd_addr = (state_reg == ST_H_TAB) ? tbl_addr(phase_cur) : tbl_addr(vib_phase_reg);
    assign sin_val     = neg_reg ? -$signed(tbl_rd) : $signed(tbl_rd);
    assign vib_prod    = $signed({1'b0, vdepth_reg}) * sin_val;
    assign factor_sum  = 34'sh0_8000_0000 + 34'(vib_prod);
    assign step_prod   = (FK_W+FACTOR_W)'(fk_reg) * (FK_W+FACTOR_W)'(factor_reg);
    assign hprod       = gain_cur * sin_val;

    // Envelope segment and divider operands
    assign s_sat    = (sustain_reg > 16'd32768) ? 16'd32768 : sustain_reg;
    assign since_a  = count_reg - attack_reg;
    assign n_plus_r = {1'b0, count_reg} + {1'b0, release_reg};

    always_comb
    begin
        div_req.numer = '0;
        div_req.denom = release_reg;
        if (count_reg < attack_reg)
        begin
            env_sel       = ENV_ATTACK;
            div_req.numer = {1'b0, count_reg, 15'd0};
            div_req.denom = attack_reg;
        end
        else if (since_a < decay_reg)
        begin
            env_sel       = ENV_DECAY;
            div_req.numer = NUMER_W'(16'd32768 - s_sat) * NUMER_W'(since_a);
            div_req.denom = decay_reg;
        end
        else if (release_reg != '0 && n_plus_r >= {1'b0, total_reg})
        begin
            env_sel       = ENV_RELEASE;
            div_req.numer = NUMER_W'(s_sat) * NUMER_W'(total_reg - count_reg);
        end
        else
        begin
            env_sel = ENV_SUSTAIN;
        end
        div_req.start = (state_reg == ST_VIB) && (env_sel != ENV_SUSTAIN);
    end

    assign env_s  = $signed({1'b0, env_reg});
    assign y_full = scale_reg[SC_W-1:30];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: state_next = tbl_done ? ST_IDLE : ST_FILL;
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd == CMD_LOAD || done_now) ? ST_EMIT : ST_VIB;
                end
            end
            ST_VIB:      state_next = ST_H_RD;
            ST_H_RD:     state_next = ST_H_TAB;
            ST_H_TAB:    state_next = ST_H_ACC;
            ST_H_ACC:    state_next = (k_reg == KW'(NUM_HARMONICS - 1)) ? ST_ENV_WAIT : ST_H_RD;
            ST_ENV_WAIT: state_next = div_rsp.busy ? ST_ENV_WAIT : ST_SCALE;
            ST_SCALE:    state_next = ST_SAT;
            ST_SAT:      state_next = ST_EMIT;
            ST_EMIT:     state_next = (!out_valid_reg || out_ready) ? ST_IDLE : ST_EMIT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
        gain_we   = in_fire && (cmd == CMD_LOAD) && gain_hit;
        phase_we  = (state_reg == ST_H_ACC);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            k_reg         <= '0;
            vib_phase_reg <= '0;
            count_reg     <= '0;
            gain_vld_reg  <= '0;
            phase_vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                k_reg <= '0;
            end
            else if (state_reg == ST_H_ACC)
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (gain_we)
            begin
                gain_vld_reg[gain_wr_addr] <= 1'b1;
            end
            if (phase_we)
            begin
                phase_vld_reg[k_reg] <= 1'b1;
            end
            if (state_reg == ST_SAT)
            begin
                vib_phase_reg <= vib_phase_reg + PHASE_W'(vstep_reg);
                count_reg     <= count_reg + LEN_W'(1);
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                neg_reg        <= vib_phase_reg[PHASE_W-1];
                fk_reg         <= FK_W'(fstep_reg);
                acc_reg        <= '0;
                res_sample_reg <= '0;
                res_fin_reg    <= done_now;
            end
            ST_VIB:
            begin
                factor_reg  <= factor_sum[FACTOR_W-1:0];
                env_sel_reg <= env_sel;
            end
            ST_H_TAB:
            begin
                phase_cur_reg <= phase_cur;
                neg_reg       <= phase_cur[PHASE_W-1];
                step_reg      <= step_prod[PHASE_W+30:31];
            end
            ST_H_ACC:
            begin
                acc_reg <= acc_reg + ACC_W'(hprod);
                fk_reg  <= fk_reg + FK_W'(fstep_reg);
            end
            ST_ENV_WAIT:
            begin
                case (env_sel_reg)
                    ENV_ATTACK:  env_reg <= ENV_W'(div_rsp.quot);
                    ENV_DECAY:   env_reg <= 17'd32768 - ENV_W'(div_rsp.quot);
                    ENV_RELEASE: env_reg <= ENV_W'(div_rsp.quot);
                    default:     env_reg <= ENV_W'(s_sat);
                endcase
            end
            ST_SCALE: scale_reg <= SC_W'(acc_reg) * SC_W'(env_s) + SC_W'(2 ** 29);
            ST_SAT:
            begin
                res_fin_reg <= 1'b0;
                if (y_full > 25'sd32767)
                begin
                    res_sample_reg <= 16'sh7FFF;
                end
                else if (y_full < -25'sd32768)
                begin
                    res_sample_reg <= 16'sh8000;
                end
                else
                begin
                    res_sample_reg <= y_full[SAMPLE_W-1:0];
                end
            end
            default: ;
        endcase
        if (emit_load)
        begin
            sample_reg <= res_sample_reg;
            fin_reg    <= res_fin_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = sample_reg;
    assign finished     = fin_reg;

endmodule

// ----- src/avs_ram.sv -----
`timescale 1ns / 1ps

module avs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/avs_div.sv -----
`timescale 1ns / 1ps

module avs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  avs_pkg::div_req_t req,
    output avs_pkg::div_rsp_t rsp
);

    import avs_pkg::*;

    logic              busy_reg;
    logic [4:0]        cnt_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [LEN_W-1:0]  den_reg;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    diff;
    logic              ge;

    // One quotient bit per cycle; quotient is known to fit 16 bits
    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'(QUOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.numer[NUMER_W-1:QUOT_W];
            low_reg  <= req.numer[QUOT_W-1:0];
            den_reg  <= req.denom;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.quot = quot_reg;

endmodule

// ----- src/avs_tbl_init.sv -----
`timescale 1ns / 1ps

module avs_tbl_init #(
    parameter int DEPTH = avs_pkg::SINE_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [avs_pkg::TBL_W-1:0] wr_data,
    output logic                      done
);

    import avs_pkg::*;

    localparam int TQ = (2 ** 30) / DEPTH;
    localparam int TR = (2 ** 30) % DEPTH;

    tinit_state_t state_reg, state_next;
    logic [AW-1:0] idx_reg;
    logic [30:0]   t_reg;
    logic [AW-1:0] frac_reg;
    logic [2:0]    k_reg;
    logic [63:0]   prod_reg;
    logic [30:0]   u_reg;
    logic [31:0]   p_reg;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic [AW:0]   frac_sum;
    logic          frac_wrap;
    logic [63:0]   rounded;

    // Shared 32x32 multiplier
    always_comb
    begin
        case (state_reg)
            TI_SQ:   begin mul_a = {1'b0, t_reg}; mul_b = {1'b0, t_reg}; end
            TI_MUL:  begin mul_a = {1'b0, u_reg}; mul_b = p_reg;         end
            TI_TP:   begin mul_a = {1'b0, t_reg}; mul_b = p_reg;         end
            TI_SC:   begin mul_a = p_reg;         mul_b = 32'd32767;     end
            default: begin mul_a = '0;            mul_b = '0;            end
        endcase
    end

    assign mul_p     = 64'(mul_a) * 64'(mul_b);
    assign frac_sum  = {1'b0, frac_reg} + (AW+1)'(TR);
    assign frac_wrap = (frac_sum >= (AW+1)'(DEPTH));
    assign rounded   = prod_reg + 64'(2 ** 29);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TI_SQ:   state_next = TI_U;
            TI_U:    state_next = TI_MUL;
            TI_MUL:  state_next = TI_SUB;
            TI_SUB:  state_next = (k_reg == 3'd0) ? TI_TP : TI_MUL;
            TI_TP:   state_next = TI_TPS;
            TI_TPS:  state_next = TI_SC;
            TI_SC:   state_next = TI_WR;
            TI_WR:   state_next = (idx_reg == AW'(DEPTH)) ? TI_DONE : TI_SQ;
            TI_DONE: state_next = TI_DONE;
            default: state_next = TI_DONE;
        endcase
    end

    // Outputs
    always_comb
    begin
        wr_en   = (state_reg == TI_WR);
        wr_addr = idx_reg;
        wr_data = rounded[30+TBL_W-1:30];
        done    = (state_reg == TI_DONE);
    end

    // Entry walk: t = floor(i * 2^30 / D) kept incrementally
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TI_SQ;
            idx_reg   <= '0;
            t_reg     <= '0;
            frac_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == TI_U)
            begin
                k_reg <= 3'd5;
            end
            else if (state_reg == TI_SUB)
            begin
                k_reg <= k_reg - 3'd1;
            end
            if (state_reg == TI_WR && idx_reg != AW'(DEPTH))
            begin
                idx_reg  <= idx_reg + AW'(1);
                t_reg    <= t_reg + 31'(TQ) + {30'd0, frac_wrap};
                frac_reg <= frac_wrap ? AW'(frac_sum - (AW+1)'(DEPTH)) : frac_sum[AW-1:0];
            end
        end
    end

    // Polynomial datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            TI_SQ, TI_MUL, TI_TP, TI_SC: prod_reg <= mul_p;
            TI_U:
            begin
                u_reg <= prod_reg[60:30];
                p_reg <= POLY_COEF[6];
            end
            TI_SUB:  p_reg <= POLY_COEF[k_reg] - prod_reg[61:30];
            TI_TPS:  p_reg <= prod_reg[61:30];
            default: ;
        endcase
    end

endmodule

// ----- src/avs_checker.sv -----
`timescale 1ns / 1ps

module avs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [avs_pkg::SAMPLE_W-1:0] sample_value,
    input logic                                finished
);

    // A stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_value) && $stable(finished))
        else $error("output beat changed while stalled");

    // A finished voice only ever reports silence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> sample_value == 0)
        else $error("finished beat with nonzero sample");

    // One item in flight: no back-to-back accepts
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // An accepted item cannot produce its beat in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("output beat appeared too early");

endmodule

bind additive_voice_synth avs_checker u_avs_checker (.*);
